@@ src/assert_macros.svh @@
// Assertion macros shared by the shortest-path block.
// No dependencies; included by each RTL file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define SSSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen outside reset
`define SSSP_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SSSP_ASSERT(label, clk, rst, prop, msg)
`define SSSP_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ src/sssp_pkg.sv @@
// Types and constants of the shortest-path block.
// No dependencies; used by every module of the block by scoped names.
package sssp_pkg;

   localparam int KIND_W = 2;
   localparam int VTX_W  = 6;
   localparam int WGT_W  = 16;
   localparam int DIST_W = 32;
   localparam int NV_W   = 7;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic CSR_NUM_VERTICES  = 1'b0;
   localparam logic CSR_SOURCE_VERTEX = 1'b1;

   localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
   localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

   // one stored edge, tail vertex in the lowest bits
   typedef struct packed {
      logic [WGT_W-1:0] weight;
      logic [VTX_W-1:0] head;
      logic [VTX_W-1:0] tail;
   } edge_type;

   // one vertex entry: predecessor and distance
   typedef struct packed {
      logic [VTX_W-1:0]  pred;
      logic [DIST_W-1:0] dist_val;
   } vert_entry_type;

   // write request into the vertex memory
   typedef struct packed {
      logic             we;
      logic [VTX_W-1:0] addr;
      vert_entry_type   data;
   } vert_wr_type;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_INIT  = 11'b000_0000_0010,
      ST_PASS  = 11'b000_0000_0100,
      ST_EREAD = 11'b000_0000_1000,
      ST_VREAD = 11'b000_0001_0000,
      ST_CALC  = 11'b000_0010_0000,
      ST_UPD   = 11'b000_0100_0000,
      ST_ENDP  = 11'b000_1000_0000,
      ST_ERD   = 11'b001_0000_0000,
      ST_EOUT  = 11'b010_0000_0000,
      ST_NEG   = 11'b100_0000_0000
   } state_type;

endpackage

@@ src/sssp_edge_ram.sv @@
// Edge list memory: one write port, one registered read port.
// Depends on sssp_pkg for the edge record type.
module sssp_edge_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sssp_pkg::edge_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output sssp_pkg::edge_type  rd_data
);

   sssp_pkg::edge_type mem [DEPTH];
   sssp_pkg::edge_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sssp_vert_ram.sv @@
// Vertex memory holding distance and predecessor per vertex.
// One write port, two registered read ports. Depends on sssp_pkg.
module sssp_vert_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                            clock,
   input  sssp_pkg::vert_wr_type           wr,
   input  logic [sssp_pkg::VTX_W-1:0]      rd_addr_a,
   input  logic [sssp_pkg::VTX_W-1:0]      rd_addr_b,
   output sssp_pkg::vert_entry_type        rd_data_a,
   output sssp_pkg::vert_entry_type        rd_data_b
);

   sssp_pkg::vert_entry_type mem [DEPTH];
   sssp_pkg::vert_entry_type rd_a_ff;
   sssp_pkg::vert_entry_type rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a[AW-1:0]];
      rd_b_ff <= mem[rd_addr_b[AW-1:0]];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/single_source_shortest_path.sv @@
// Top level of the shortest-path block: ports, sequencer, relaxation datapath.
// Depends on sssp_pkg, sssp_edge_ram, sssp_vert_ram and assert_macros.svh.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  req_     | in        | req_tvalid/tready  | tuser kind, tdata edge from/to/weight
//  rsp_     | out       | rsp_tvalid/tready  | tdata per-vertex result, tuser, tlast
//  csr_     | in        | csr_valid/ready    | csr_index, csr_data
//
// Load, clear and unused items are handled in the idle state. A run sets up
// the source, then makes P passes (apply passes plus the cycle check) over
// E stored edges, then sends one result per vertex, or a single cycle result,
// waiting on any output stall. Each edge goes through the edge memory read,
// the vertex memory read, the saturating add, then compare and write back.
// No item is taken during a run. Reset is synchronous; the output register
// lets a new item in while the last result waits.
`include "assert_macros.svh"

module single_source_shortest_path #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // edge_from[5:0], edge_to[11:6], edge_weight[27:12]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // vertex_index[5:0], distance[37:6], reachable[38],
                                    // pred_vertex[44:39], has_pred[45], edges_dropped[46]
   output logic        rsp_tuser,   // negative_cycle[0]
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int VA_W  = $clog2(MAX_VERTICES);
   localparam logic [CNT_W-1:0] EDGE_CAP = CNT_W'(MAX_EDGES);
   localparam logic [sssp_pkg::NV_W-1:0] VTX_CAP = sssp_pkg::NV_W'(MAX_VERTICES);

   sssp_pkg::state_type state_ff, state_in;

   logic [sssp_pkg::NV_W-1:0]   nv_ff;
   logic [sssp_pkg::VTX_W-1:0]  src_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        dropped_ff, dropped_in;
   logic [CNT_W-1:0]            j_ff, j_in;
   logic [sssp_pkg::NV_W-1:0]   passes_ff, passes_in;
   logic                        checking_ff, checking_in;
   logic                        changed_ff, changed_in;
   logic                        negcyc_ff, negcyc_in;
   logic [MAX_VERTICES-1:0]     reached_ff, reached_in;
   logic [MAX_VERTICES-1:0]     haspred_ff, haspred_in;
   logic [sssp_pkg::DIST_W-1:0] cand_ff, cand_in;
   logic [sssp_pkg::DIST_W-1:0] dv_ff, dv_in;
   logic [sssp_pkg::VTX_W-1:0]  emit_ff, emit_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [sssp_pkg::NV_W-1:0]  vlim;
   logic [sssp_pkg::KIND_W-1:0] req_kind;
   sssp_pkg::edge_type         req_edge;
   sssp_pkg::edge_type         erd;
   logic                       ewe;
   sssp_pkg::vert_wr_type      vram_wr;
   logic [sssp_pkg::VTX_W-1:0] vaddr_a;
   sssp_pkg::vert_entry_type   vrd_a, vrd_b;
   logic [sssp_pkg::DIST_W:0]  sum;
   logic [sssp_pkg::DIST_W-1:0] sat;
   logic                       edge_ok;
   logic                       relax;
   logic                       out_free;
   logic                       emit_reached;
   logic                       emit_haspred;

   // vertex count as used by the search
   always_comb begin
      if (nv_ff == '0) begin
         vlim = sssp_pkg::NV_W'(1);
      end else if (nv_ff > VTX_CAP) begin
         vlim = VTX_CAP;
      end else begin
         vlim = nv_ff;
      end
   end

   assign req_kind = req_tuser;
   assign req_edge = sssp_pkg::edge_type'(req_tdata[27:0]);
   assign req_tready = (state_ff == sssp_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;

   // memories
   sssp_edge_ram #(
      .DEPTH (MAX_EDGES),
      .AW    (EA_W)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (ewe),
      .wr_addr (count_ff[EA_W-1:0]),
      .wr_data (req_edge),
      .rd_addr (j_ff[EA_W-1:0]),
      .rd_data (erd)
   );

   assign vaddr_a = (state_ff == sssp_pkg::ST_ERD || state_ff == sssp_pkg::ST_EOUT) ?
                    emit_ff : erd.tail;

   sssp_vert_ram #(
      .DEPTH (MAX_VERTICES),
      .AW    (VA_W)
   ) u_vert_ram (
      .clock     (clock),
      .wr        (vram_wr),
      .rd_addr_a (vaddr_a),
      .rd_addr_b (erd.head),
      .rd_data_a (vrd_a),
      .rd_data_b (vrd_b)
   );

   // saturating candidate distance
   assign sum = {vrd_a.dist_val[sssp_pkg::DIST_W-1], vrd_a.dist_val} +
                {{(sssp_pkg::DIST_W + 1 - sssp_pkg::WGT_W){erd.weight[sssp_pkg::WGT_W-1]}},
                 erd.weight};
   always_comb begin
      if (sum[sssp_pkg::DIST_W] != sum[sssp_pkg::DIST_W-1]) begin
         sat = sum[sssp_pkg::DIST_W] ? sssp_pkg::DIST_MIN : sssp_pkg::DIST_MAX;
      end else begin
         sat = sum[sssp_pkg::DIST_W-1:0];
      end
   end

   // edge usable this run and relaxable
   assign edge_ok = ({1'b0, erd.tail} < vlim) && ({1'b0, erd.head} < vlim) &&
                    reached_ff[erd.tail[VA_W-1:0]];
   assign relax   = edge_ok && (!reached_ff[erd.head[VA_W-1:0]] ||
                    ($signed(cand_ff) < $signed(dv_ff)));

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign emit_reached = reached_ff[emit_ff[VA_W-1:0]];
   assign emit_haspred = haspred_ff[emit_ff[VA_W-1:0]];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      j_in         = j_ff;
      passes_in    = passes_ff;
      checking_in  = checking_ff;
      changed_in   = changed_ff;
      negcyc_in    = negcyc_ff;
      reached_in   = reached_ff;
      haspred_in   = haspred_ff;
      cand_in      = cand_ff;
      dv_in        = dv_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      ewe          = 1'b0;
      vram_wr      = '0;

      unique case (state_ff)
         sssp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  sssp_pkg::KIND_LOAD: begin
                     if (count_ff == EDGE_CAP || {1'b0, req_edge.tail} >= vlim ||
                         {1'b0, req_edge.head} >= vlim) begin
                        dropped_in = 1'b1;
                     end else begin
                        ewe      = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  sssp_pkg::KIND_RUN: begin
                     state_in = sssp_pkg::ST_INIT;
                  end
                  sssp_pkg::KIND_CLEAR: begin
                     count_in   = '0;
                     dropped_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // fresh marks, source at distance zero
         sssp_pkg::ST_INIT: begin
            reached_in  = '0;
            haspred_in  = '0;
            negcyc_in   = 1'b0;
            passes_in   = '0;
            checking_in = (vlim == sssp_pkg::NV_W'(1));
            if ({1'b0, src_ff} < vlim) begin
               reached_in[src_ff[VA_W-1:0]] = 1'b1;
               vram_wr.we   = 1'b1;
               vram_wr.addr = src_ff;
            end
            state_in = sssp_pkg::ST_PASS;
         end
         sssp_pkg::ST_PASS: begin
            j_in       = '0;
            changed_in = 1'b0;
            state_in   = (count_ff == '0) ? sssp_pkg::ST_ENDP : sssp_pkg::ST_EREAD;
         end
         sssp_pkg::ST_EREAD: begin
            state_in = sssp_pkg::ST_VREAD;
         end
         sssp_pkg::ST_VREAD: begin
            state_in = sssp_pkg::ST_CALC;
         end
         sssp_pkg::ST_CALC: begin
            cand_in  = sat;
            dv_in    = vrd_b.dist_val;
            state_in = sssp_pkg::ST_UPD;
         end
         // compare, then write back; the checking pass only sets negcyc
         sssp_pkg::ST_UPD: begin
            if (relax) begin
               if (checking_ff) begin
                  negcyc_in = 1'b1;
               end else begin
                  vram_wr.we            = 1'b1;
                  vram_wr.addr          = erd.head;
                  vram_wr.data.dist_val = cand_ff;
                  vram_wr.data.pred     = erd.tail;
                  reached_in[erd.head[VA_W-1:0]] = 1'b1;
                  haspred_in[erd.head[VA_W-1:0]] = 1'b1;
                  changed_in = 1'b1;
               end
            end
            j_in     = j_ff + CNT_W'(1);
            state_in = (j_ff + CNT_W'(1) == count_ff) ? sssp_pkg::ST_ENDP :
                       sssp_pkg::ST_EREAD;
         end
         sssp_pkg::ST_ENDP: begin
            if (checking_ff) begin
               emit_in  = '0;
               state_in = negcyc_ff ? sssp_pkg::ST_NEG : sssp_pkg::ST_ERD;
            end else begin
               passes_in = passes_ff + sssp_pkg::NV_W'(1);
               if (!changed_ff ||
                   (passes_ff + sssp_pkg::NV_W'(1)) >= (vlim - sssp_pkg::NV_W'(1))) begin
                  checking_in = 1'b1;
               end
               state_in = sssp_pkg::ST_PASS;
            end
         end
         sssp_pkg::ST_ERD: begin
            state_in = sssp_pkg::ST_EOUT;
         end
         // one result per vertex
         sssp_pkg::ST_EOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = 1'b0;
               rsp_last_in  = ({1'b0, emit_ff} == vlim - sssp_pkg::NV_W'(1));
               rsp_data_in  = {1'b0, dropped_ff, emit_haspred,
                               emit_haspred ? vrd_a.pred : sssp_pkg::VTX_W'(0),
                               emit_reached,
                               emit_reached ? vrd_a.dist_val : sssp_pkg::DIST_W'(0),
                               emit_ff};
               if ({1'b0, emit_ff} == vlim - sssp_pkg::NV_W'(1)) begin
                  state_in = sssp_pkg::ST_IDLE;
               end else begin
                  emit_in  = emit_ff + sssp_pkg::VTX_W'(1);
                  state_in = sssp_pkg::ST_ERD;
               end
            end
         end
         // sole cycle result
         sssp_pkg::ST_NEG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = {1'b0, dropped_ff, 46'd0};
               state_in     = sssp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sssp_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sssp_pkg::ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         reached_ff   <= '0;
         haspred_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         reached_ff   <= reached_in;
         haspred_ff   <= haspred_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff  <= sssp_pkg::NV_W'(1);
         src_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sssp_pkg::CSR_NUM_VERTICES:  nv_ff  <= csr_data;
            sssp_pkg::CSR_SOURCE_VERTEX: src_ff <= csr_data[sssp_pkg::VTX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      passes_ff   <= passes_in;
      checking_ff <= checking_in;
      changed_ff  <= changed_in;
      negcyc_ff   <= negcyc_in;
      cand_ff     <= cand_in;
      dv_ff       <= dv_in;
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `SSSP_ASSERT(a_neg_is_last, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tlast, "cycle result not last")
   `SSSP_NEVER(a_count_cap, clock, reset, count_ff > EDGE_CAP, "edge count beyond capacity")
   `SSSP_NEVER(a_pred_reached, clock, reset, |(haspred_ff & ~reached_ff), "predecessor on unreached vertex")
   `SSSP_ASSERT(a_vram_wr_state, clock, reset, vram_wr.we |-> (state_ff == sssp_pkg::ST_INIT || state_ff == sssp_pkg::ST_UPD), "vertex write outside update")

endmodule

@@ sim/single_source_shortest_path_tb.sv @@
// Testbench for single_source_shortest_path: edge loads, searches, clears and
// configuration writes, each result checked against a built-in path solver.
// Depends on sssp_pkg and the single_source_shortest_path RTL.
module single_source_shortest_path_tb;

   localparam int MAX_V        = 64;
   localparam int MAX_E        = 1024;
   localparam int HALF_PERIOD  = 10;
   localparam int RANDOM_ITEMS = 215;
   localparam int HOLD_CYCLES  = 1500;
   localparam int SETTLE_WAIT  = 16;
   localparam logic [sssp_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

   // one expected result item
   typedef struct {
      logic [5:0]  vertex;
      logic [31:0] distance;
      logic        reachable;
      logic [5:0]  pred;
      logic        has_pred;
      logic        neg_cycle;
      logic        dropped;
      logic        last;
   } path_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // edge_from[5:0], edge_to[11:6], edge_weight[27:12]
   logic [1:0]  req_tuser  = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // vertex_index, distance, reachable, pred_vertex,
                                   // has_pred, edges_dropped
   logic        rsp_tuser;         // negative_cycle[0]
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [6:0]  csr_data   = '0;

   // solver state
   sssp_pkg::edge_type edge_list [MAX_E];
   int unsigned  edge_total   = 0;
   bit           dropped_any  = 0;
   logic [6:0]   cfg_vertices = 7'd1;
   logic [5:0]   cfg_source   = 6'd0;
   int           dist_est [MAX_V];
   bit           reached [MAX_V];
   bit           pred_set [MAX_V];
   logic [5:0]   pred_of [MAX_V];
   path_result_type pending_results [$];

   int errors       = 0;
   int burst_left   = 0;
   int random_items = 0;
   bit hold_request = 0;

   always #(HALF_PERIOD) clock = ~clock;

   single_source_shortest_path u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // vertex count with out-of-range settings folded in
   function automatic int unsigned active_vertices();
      if (cfg_vertices == 0) return 1;
      if (cfg_vertices > MAX_V) return MAX_V;
      return cfg_vertices;
   endfunction

   function automatic int sat_sum(int a, int b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'($signed(sssp_pkg::DIST_MAX))) return $signed(sssp_pkg::DIST_MAX);
      if (s < longint'($signed(sssp_pkg::DIST_MIN))) return $signed(sssp_pkg::DIST_MIN);
      return int'(s);
   endfunction

   // one sweep over the stored edges in load order; without apply it only
   // reports whether any edge could still be relaxed
   function automatic bit relax_all(int unsigned n, bit apply);
      bit          changed;
      int unsigned u;
      int unsigned v;
      int          cand;
      changed = 0;
      for (int j = 0; j < edge_total; j++) begin
         u = edge_list[j].tail;
         v = edge_list[j].head;
         if (u >= n || v >= n || !reached[u]) continue;
         cand = sat_sum(dist_est[u], int'($signed(edge_list[j].weight)));
         if (!reached[v] || cand < dist_est[v]) begin
            if (!apply) return 1;
            dist_est[v] = cand;
            reached[v]  = 1;
            pred_of[v]  = u[5:0];
            pred_set[v] = 1;
            changed     = 1;
         end
      end
      return changed;
   endfunction

   // search from the configured source and queue the results it yields
   function automatic void solve_paths();
      int unsigned  n;
      path_result_type r;
      n = active_vertices();
      for (int i = 0; i < MAX_V; i++) begin
         dist_est[i] = 0;
         reached[i]  = 0;
         pred_set[i] = 0;
         pred_of[i]  = '0;
      end
      if (cfg_source < n) reached[cfg_source] = 1;
      for (int unsigned p = 0; p + 1 < n; p++) begin
         if (!relax_all(n, 1)) break;
      end
      r.dropped = dropped_any;
      if (relax_all(n, 0)) begin
         r.vertex    = '0;
         r.distance  = '0;
         r.reachable = 0;
         r.pred      = '0;
         r.has_pred  = 0;
         r.neg_cycle = 1;
         r.last      = 1;
         pending_results.push_back(r);
         return;
      end
      for (int unsigned i = 0; i < n; i++) begin
         r.vertex    = i[5:0];
         r.distance  = reached[i] ? dist_est[i] : 0;
         r.reachable = reached[i];
         r.pred      = pred_set[i] ? pred_of[i] : '0;
         r.has_pred  = pred_set[i];
         r.neg_cycle = 0;
         r.last      = (i + 1 == n);
         pending_results.push_back(r);
      end
   endfunction

   function automatic void model_item(logic [1:0] kind, logic [5:0] tail,
                                      logic [5:0] head, logic [15:0] weight);
      int unsigned n;
      n = active_vertices();
      case (kind)
         sssp_pkg::KIND_LOAD: begin
            if (edge_total >= MAX_E || tail >= n || head >= n) begin
               dropped_any = 1;
            end else begin
               edge_list[edge_total] = '{weight: weight, head: head, tail: tail};
               edge_total++;
            end
         end
         sssp_pkg::KIND_RUN: solve_paths();
         sssp_pkg::KIND_CLEAR: begin
            edge_total  = 0;
            dropped_any = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // result checker
   always @(posedge clock) begin : check_results
      path_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result expected none, got %h", $time, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            check_field("vertex_index", want.vertex, rsp_tdata[5:0]);
            check_field("distance", want.distance, rsp_tdata[37:6]);
            check_field("reachable", want.reachable, rsp_tdata[38]);
            check_field("pred_vertex", want.pred, rsp_tdata[44:39]);
            check_field("has_pred", want.has_pred, rsp_tdata[45]);
            check_field("edges_dropped", want.dropped, rsp_tdata[46]);
            check_field("negative_cycle", want.neg_cycle, rsp_tuser);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   // receiver: rotating stall pattern, reloaded as all ones or random, plus long hold-offs
   initial begin : rsp_stall_pattern
      logic [15:0] pattern;
      int          hold_left;
      int          phase;
      pattern   = '1;
      hold_left = 0;
      phase     = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (phase == 0) begin
               case ($urandom_range(0, 2))
                  0:       pattern = '1;
                  1:       pattern = 16'($urandom);
                  default: pattern = 16'($urandom) | 16'($urandom);
               endcase
               phase = 64;
            end
            phase--;
            rsp_tready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
         end
      end
   end

   // offer one item, wait for it to be taken, then maybe pause
   task automatic send_item(logic [1:0] kind, logic [5:0] tail, logic [5:0] head,
                            logic [15:0] weight);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, weight, head, tail};
      do @(posedge clock); while (!req_tready);
      model_item(kind, tail, head, weight);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_run();
      send_item(sssp_pkg::KIND_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
   endtask

   task automatic send_clear();
      send_item(sssp_pkg::KIND_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
   endtask

   // stop offering, wait for every expected result and let trailing loads finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [6:0] value);
      settle();
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == sssp_pkg::CSR_NUM_VERTICES) cfg_vertices = value;
      else cfg_source = value[5:0];
      csr_valid <= 1'b0;
   endtask

   function automatic logic [5:0] pick_vertex(int unsigned n);
      if ($urandom_range(0, 9) == 0) return 6'($urandom);
      return 6'($urandom_range(0, n - 1));
   endfunction

   function automatic logic [15:0] pick_weight();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16'($urandom_range(0, 60));
      if (r < 9) return 16'(-int'($urandom_range(1, 20)));
      return 16'($urandom);
   endfunction

   // search straight after reset: one vertex, the source itself
   task automatic test_reset_defaults();
      send_run();
      settle();
   endtask

   // weight extremes, dropped endpoints, the spare kind and a clear
   task automatic test_edge_extremes();
      csr_write(sssp_pkg::CSR_NUM_VERTICES, 7'd4);
      csr_write(sssp_pkg::CSR_SOURCE_VERTEX, 7'd0);
      send_clear();
      send_item(sssp_pkg::KIND_LOAD, 6'd0, 6'd1, 16'h7FFF);
      send_item(sssp_pkg::KIND_LOAD, 6'd1, 6'd2, 16'h8000);
      send_item(sssp_pkg::KIND_LOAD, 6'd0, 6'd2, 16'd5);
      send_item(sssp_pkg::KIND_LOAD, 6'd2, 6'd3, 16'd0);
      send_item(sssp_pkg::KIND_LOAD, 6'd63, 6'd3, 16'd1);   // tail out of range
      send_item(sssp_pkg::KIND_LOAD, 6'd3, 6'd4, 16'd1);    // head out of range
      send_run();
      send_item(KIND_SPARE, 6'h3F, 6'h3F, 16'hFFFF);
      send_clear();
      send_run();
      settle();
   endtask

   task automatic test_negative_cycle();
      csr_write(sssp_pkg::CSR_NUM_VERTICES, 7'd3);
      csr_write(sssp_pkg::CSR_SOURCE_VERTEX, 7'd1);
      send_clear();
      send_item(sssp_pkg::KIND_LOAD, 6'd1, 6'd2, 16'(-5));
      send_item(sssp_pkg::KIND_LOAD, 6'd2, 6'd1, 16'd2);
      send_item(sssp_pkg::KIND_LOAD, 6'd0, 6'd1, 16'd1);
      send_run();
      // same shape with the cycle broken
      send_clear();
      send_item(sssp_pkg::KIND_LOAD, 6'd1, 6'd2, 16'(-5));
      send_item(sssp_pkg::KIND_LOAD, 6'd2, 6'd0, 16'd4);
      send_run();
      settle();
   endtask

   // source beyond the vertex count, folded vertex counts, stale edges
   task automatic test_vertex_range();
      csr_write(sssp_pkg::CSR_SOURCE_VERTEX, 7'd5);
      send_run();
      csr_write(sssp_pkg::CSR_NUM_VERTICES, 7'd0);
      csr_write(sssp_pkg::CSR_SOURCE_VERTEX, 7'd0);
      send_run();
      csr_write(sssp_pkg::CSR_NUM_VERTICES, 7'h7F);
      csr_write(sssp_pkg::CSR_SOURCE_VERTEX, 7'h47);      // upper bit ignored: source 7
      send_item(sssp_pkg::KIND_LOAD, 6'd7, 6'd63, 16'd100);
      send_item(sssp_pkg::KIND_LOAD, 6'd63, 6'd0, 16'(-3));
      send_run();
      csr_write(sssp_pkg::CSR_NUM_VERTICES, 7'd8);
      csr_write(sssp_pkg::CSR_SOURCE_VERTEX, 7'd0);
      send_clear();
      send_item(sssp_pkg::KIND_LOAD, 6'd0, 6'd6, 16'd2);
      send_item(sssp_pkg::KIND_LOAD, 6'd0, 6'd2, 16'd3);
      send_item(sssp_pkg::KIND_LOAD, 6'd6, 6'd1, 16'd1);
      csr_write(sssp_pkg::CSR_NUM_VERTICES, 7'd4);
      send_run();
      settle();
   endtask

   // receiver holds off during a full-size search while items keep coming
   task automatic test_backpressure();
      csr_write(sssp_pkg::CSR_NUM_VERTICES, 7'd64);
      csr_write(sssp_pkg::CSR_SOURCE_VERTEX, 7'd0);
      send_clear();
      repeat (12)
         send_item(sssp_pkg::KIND_LOAD, 6'($urandom), 6'($urandom),
                   16'($urandom_range(0, 100)));
      hold_request = 1;
      send_run();
      repeat (8)
         send_item(sssp_pkg::KIND_LOAD, 6'($urandom), 6'($urandom),
                   16'($urandom_range(0, 100)));
      send_run();
      settle();
   endtask

   // random graphs: mostly well-formed load sequences ending in a search
   task automatic test_random_graphs();
      int unsigned n;
      logic [6:0]  nv;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 19))
               0:       nv = 7'd0;
               1:       nv = 7'd64;
               2:       nv = 7'($urandom_range(65, 127));
               default: nv = 7'($urandom_range(2, 12));
            endcase
            n = (nv == 0) ? 1 : (nv > MAX_V) ? MAX_V : nv;
            csr_write(sssp_pkg::CSR_NUM_VERTICES, nv);
            csr_write(sssp_pkg::CSR_SOURCE_VERTEX, ($urandom_range(0, 9) == 0) ?
                      7'($urandom) : 7'($urandom_range(0, n - 1)));
         end
         n = active_vertices();
         if ($urandom_range(0, 9) < 7) begin
            send_clear();
            random_items++;
         end
         repeat ($urandom_range(0, 20)) begin
            if ($urandom_range(0, 19) == 0)
               send_item(KIND_SPARE, 6'($urandom), 6'($urandom), 16'($urandom));
            send_item(sssp_pkg::KIND_LOAD, pick_vertex(n), pick_vertex(n), pick_weight());
            random_items++;
         end
         send_run();
         random_items++;
         if ($urandom_range(0, 4) == 0) begin
            send_run();
            random_items++;
         end
      end
      settle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_edge_extremes();
      test_negative_cycle();
      test_vertex_range();
      test_backpressure();
      test_random_graphs();
      settle();
      if (errors == 0)
         $display("single_source_shortest_path verification clean");
      else
         $display("single_source_shortest_path verification failed");
      $finish;
   end

   // run limit
   initial begin
      #500_000_000;
      $display("single_source_shortest_path verification failed");
      $finish;
   end

endmodule
